[hdl/zba_pkg.sv]
package zba_pkg;

   localparam int BITMAP_WORDS = 256;
   localparam int WORD_W       = 32;
   localparam int BIT_W        = $clog2(WORD_W);
   localparam int MAP_ADDR_W   = $clog2(BITMAP_WORDS);
   localparam int GBIT_W       = MAP_ADDR_W + BIT_W;
   localparam int BLOCK_W      = 16;
   localparam int INDEX_W      = 8;
   localparam int OP_W         = 2;
   localparam int STATUS_W     = 2;
   localparam int CSR_INDEX_W  = 1;
   // signed width for first_data_zone + bit - 1
   localparam int SUM_W        = ((GBIT_W > BLOCK_W) ? GBIT_W : BLOCK_W) + 2;
   // wide enough for block - first_data_zone + 1
   localparam int FBIT_W       = BLOCK_W + 1;

   localparam logic [OP_W-1:0] OP_ALLOC = 2'd0;
   localparam logic [OP_W-1:0] OP_FREE  = 2'd1;
   localparam logic [OP_W-1:0] OP_LOAD  = 2'd2;

   localparam logic [STATUS_W-1:0] STATUS_OK       = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_NO_SPACE = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_INVALID  = 2'd2;

   localparam logic [CSR_INDEX_W-1:0] CSR_FIRST_DATA_ZONE = 1'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_ZONE_COUNT      = 1'd1;

   typedef struct packed {
      logic                  rd_en;
      logic [MAP_ADDR_W-1:0] rd_addr;
      logic                  wr_en;
      logic [MAP_ADDR_W-1:0] wr_addr;
      logic [WORD_W-1:0]     wr_data;
   } map_req_type;

   // lowest clear bit of a word that is not all ones
   function automatic logic [BIT_W-1:0] lowest_clear(input logic [WORD_W-1:0] word);
      logic [BIT_W-1:0] pos;
      pos = '0;
      for (int i = WORD_W - 1; i >= 0; i--) begin
         if (!word[i]) begin
            pos = BIT_W'(i);
         end
      end
      return pos;
   endfunction

endpackage

[hdl/zba_ram.sv]
module zba_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[hdl/zba_map.sv]
module zba_map
   import zba_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  map_req_type       map_req,
   output logic [WORD_W-1:0] rd_data
);

   logic [BITMAP_WORDS-1:0] valid_ff;
   logic                    rd_valid_ff;
   logic [WORD_W-1:0]       ram_rd_data;

   zba_ram #(
      .WIDTH(WORD_W),
      .DEPTH(BITMAP_WORDS)
   ) u_ram (
      .clock  (clock),
      .rd_en  (map_req.rd_en),
      .rd_addr(map_req.rd_addr),
      .rd_data(ram_rd_data),
      .wr_en  (map_req.wr_en),
      .wr_addr(map_req.wr_addr),
      .wr_data(map_req.wr_data)
   );

   // a word never written since reset reads as all clear
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff    <= '0;
         rd_valid_ff <= 1'b0;
      end else begin
         if (map_req.wr_en) begin
            valid_ff[map_req.wr_addr] <= 1'b1;
         end
         if (map_req.rd_en) begin
            rd_valid_ff <= valid_ff[map_req.rd_addr];
         end
      end
   end

   assign rd_data = rd_valid_ff ? ram_rd_data : '0;

endmodule

[hdl/zba_ctrl.sv]
module zba_ctrl
   import zba_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  logic [OP_W-1:0]     req_operation,
   input  logic [BLOCK_W-1:0]  req_block_number,
   input  logic [INDEX_W-1:0]  req_word_index,
   input  logic [WORD_W-1:0]   req_word_data,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic [STATUS_W-1:0] rsp_status,
   output logic [BLOCK_W-1:0]  rsp_allocated_block,
   input  logic [BLOCK_W-1:0]  first_data_zone,
   input  logic [BLOCK_W-1:0]  zone_count,
   output map_req_type         map_req,
   input  logic [WORD_W-1:0]   map_rd_data
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN,
      ST_CHECK,
      ST_FREE_CHK,
      ST_FREE_WR,
      ST_LOAD,
      ST_RESPOND
   } state_type;

   localparam logic [MAP_ADDR_W:0] WORDS_END = (MAP_ADDR_W + 1)'(BITMAP_WORDS);

   state_type             state_ff,  state_in;
   logic [MAP_ADDR_W:0]   issue_ff,  issue_in;
   logic                  chk_valid_ff, chk_valid_in;
   logic [MAP_ADDR_W-1:0] chk_addr_ff, chk_addr_in;
   logic [BLOCK_W-1:0]    hold_blk_ff, hold_blk_in;
   logic [INDEX_W-1:0]    hold_idx_ff, hold_idx_in;
   logic [WORD_W-1:0]     hold_data_ff, hold_data_in;
   logic [GBIT_W-1:0]     gbit_ff, gbit_in;
   logic [STATUS_W-1:0]   res_status_ff, res_status_in;
   logic [BLOCK_W-1:0]    res_block_ff, res_block_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [STATUS_W-1:0]   rsp_status_ff, rsp_status_in;
   logic [BLOCK_W-1:0]    rsp_block_ff, rsp_block_in;

   logic signed [SUM_W-1:0] alloc_block;
   logic [FBIT_W-1:0]       free_bit;
   logic [FBIT_W-BIT_W-1:0] free_word;
   logic                    free_range_ok;

   assign alloc_block = $signed(SUM_W'(gbit_ff)) + $signed(SUM_W'(first_data_zone))
                        - $signed(SUM_W'(1));
   assign free_bit    = FBIT_W'(hold_blk_ff) - FBIT_W'(first_data_zone) + FBIT_W'(1);
   assign free_word   = free_bit[FBIT_W-1:BIT_W];
   assign free_range_ok = (hold_blk_ff >= first_data_zone) && (hold_blk_ff < zone_count);

   always_comb begin
      state_in      = state_ff;
      issue_in      = issue_ff;
      chk_valid_in  = 1'b0;
      chk_addr_in   = chk_addr_ff;
      hold_blk_in   = hold_blk_ff;
      hold_idx_in   = hold_idx_ff;
      hold_data_in  = hold_data_ff;
      gbit_in       = gbit_ff;
      res_status_in = res_status_ff;
      res_block_in  = res_block_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_status_in = rsp_status_ff;
      rsp_block_in  = rsp_block_ff;
      map_req       = '0;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               hold_blk_in   = req_block_number;
               hold_idx_in   = req_word_index;
               hold_data_in  = req_word_data;
               res_status_in = STATUS_OK;
               res_block_in  = '0;
               issue_in      = '0;
               unique case (req_operation)
                  OP_ALLOC: state_in = ST_SCAN;
                  OP_FREE:  state_in = ST_FREE_CHK;
                  OP_LOAD:  state_in = ST_LOAD;
                  default: begin
                     res_status_in = STATUS_INVALID;
                     state_in      = ST_RESPOND;
                  end
               endcase
            end
         end
         ST_SCAN: begin
            // one word read a cycle; the word read last cycle is checked now
            if (issue_ff < WORDS_END) begin
               map_req.rd_en = 1'b1;
               map_req.rd_addr = issue_ff[MAP_ADDR_W-1:0];
               issue_in     = issue_ff + (MAP_ADDR_W + 1)'(1);
               chk_valid_in = 1'b1;
               chk_addr_in  = issue_ff[MAP_ADDR_W-1:0];
            end
            if (chk_valid_ff && (map_rd_data != '1)) begin
               hold_data_in = map_rd_data;
               gbit_in      = {chk_addr_ff, lowest_clear(map_rd_data)};
               chk_valid_in = 1'b0;
               state_in     = ST_CHECK;
            end else if (!chk_valid_ff && (issue_ff == WORDS_END)) begin
               res_status_in = STATUS_NO_SPACE;
               state_in      = ST_RESPOND;
            end
         end
         ST_CHECK: begin
            if (alloc_block[SUM_W-1] || (alloc_block >= $signed(SUM_W'(zone_count)))) begin
               res_status_in = STATUS_NO_SPACE;
            end else begin
               map_req.wr_en   = 1'b1;
               map_req.wr_addr = gbit_ff[GBIT_W-1:BIT_W];
               map_req.wr_data = hold_data_ff | (WORD_W'(1) << gbit_ff[BIT_W-1:0]);
               res_block_in    = alloc_block[BLOCK_W-1:0];
            end
            state_in = ST_RESPOND;
         end
         ST_FREE_CHK: begin
            priority if (!free_range_ok) begin
               res_status_in = STATUS_INVALID;
               state_in      = ST_RESPOND;
            end else if (32'(free_word) < 32'(BITMAP_WORDS)) begin
               map_req.rd_en   = 1'b1;
               map_req.rd_addr = MAP_ADDR_W'(free_word);
               gbit_in         = {MAP_ADDR_W'(free_word), free_bit[BIT_W-1:0]};
               state_in        = ST_FREE_WR;
            end else begin
               // bit lies past the bitmap: nothing to clear
               state_in = ST_RESPOND;
            end
         end
         ST_FREE_WR: begin
            map_req.wr_en   = 1'b1;
            map_req.wr_addr = gbit_ff[GBIT_W-1:BIT_W];
            map_req.wr_data = map_rd_data & ~(WORD_W'(1) << gbit_ff[BIT_W-1:0]);
            state_in        = ST_RESPOND;
         end
         ST_LOAD: begin
            if (32'(hold_idx_ff) < 32'(BITMAP_WORDS)) begin
               map_req.wr_en   = 1'b1;
               map_req.wr_addr = MAP_ADDR_W'(hold_idx_ff);
               map_req.wr_data = hold_data_ff;
            end
            state_in = ST_RESPOND;
         end
         ST_RESPOND: begin
            // hold until the output register is free
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = res_status_ff;
               rsp_block_in  = res_block_ff;
               state_in      = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         chk_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         chk_valid_ff <= chk_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      issue_ff      <= issue_in;
      chk_addr_ff   <= chk_addr_in;
      hold_blk_ff   <= hold_blk_in;
      hold_idx_ff   <= hold_idx_in;
      hold_data_ff  <= hold_data_in;
      gbit_ff       <= gbit_in;
      res_status_ff <= res_status_in;
      res_block_ff  <= res_block_in;
      rsp_status_ff <= rsp_status_in;
      rsp_block_ff  <= rsp_block_in;
   end

   assign req_stall           = (state_ff != ST_IDLE);
   assign rsp_valid           = rsp_valid_ff;
   assign rsp_status          = rsp_status_ff;
   assign rsp_allocated_block = rsp_block_ff;

   a_no_rd_wr_overlap: assert property (@(posedge clock) disable iff (reset)
      !(map_req.rd_en && map_req.wr_en))
      else $error("bitmap read and write in the same cycle");

   a_rsp_from_respond: assert property (@(posedge clock) disable iff (reset)
      (!$past(rsp_valid_ff) && rsp_valid_ff) |-> $past(state_ff == ST_RESPOND))
      else $error("result raised outside the respond step");

   a_issue_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SCAN) |-> (issue_ff <= WORDS_END))
      else $error("scan read address ran past the bitmap");

   a_accept_leaves_idle: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> (state_ff != ST_IDLE))
      else $error("accepted request did not start");

   a_write_only_in_update: assert property (@(posedge clock) disable iff (reset)
      map_req.wr_en |-> (state_ff == ST_CHECK || state_ff == ST_FREE_WR
                         || state_ff == ST_LOAD))
      else $error("bitmap written outside an update step");

endmodule

[hdl/zone_bitmap_allocator_core.sv]
// First-fit zone allocator over a 256 x 32-bit bitmap held in one synchronous RAM, one
// request in flight at a time. Allocate scans the bitmap one word per cycle and takes
// the lowest clear bit, stopping at the first word that holds one or after the last
// word. Free steps through range check, read, write back and respond; load through
// write and respond. Each result then sits in an output register until taken; the next
// request is taken as soon as the previous one has been moved into that register. No
// clearing pass is needed after reset: words never loaded or written read as all clear.
// Write first_data_zone and zone_count only while no request is outstanding.
module zone_bitmap_allocator_core
   import zba_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  logic [OP_W-1:0]        req_operation,
   input  logic [BLOCK_W-1:0]     req_block_number,
   input  logic [INDEX_W-1:0]     req_word_index,
   input  logic [WORD_W-1:0]      req_word_data,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output logic [STATUS_W-1:0]    rsp_status,
   output logic [BLOCK_W-1:0]     rsp_allocated_block,
   input  logic                   csr_write_enable,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [BLOCK_W-1:0]     csr_write_data
);

   logic [BLOCK_W-1:0] first_data_zone_ff;
   logic [BLOCK_W-1:0] zone_count_ff;
   map_req_type        map_req;
   logic [WORD_W-1:0]  map_rd_data;

   always_ff @(posedge clock) begin
      if (reset) begin
         first_data_zone_ff <= BLOCK_W'(1);
         zone_count_ff      <= '0;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            CSR_FIRST_DATA_ZONE: first_data_zone_ff <= csr_write_data;
            CSR_ZONE_COUNT:      zone_count_ff      <= csr_write_data;
            default: ;
         endcase
      end
   end

   zba_map u_map (
      .clock  (clock),
      .reset  (reset),
      .map_req(map_req),
      .rd_data(map_rd_data)
   );

   zba_ctrl u_ctrl (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_operation      (req_operation),
      .req_block_number   (req_block_number),
      .req_word_index     (req_word_index),
      .req_word_data      (req_word_data),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_status         (rsp_status),
      .rsp_allocated_block(rsp_allocated_block),
      .first_data_zone    (first_data_zone_ff),
      .zone_count         (zone_count_ff),
      .map_req            (map_req),
      .map_rd_data        (map_rd_data)
   );

endmodule
